[design/lru_key_value_cache_macros.svh]
// Assertion macros shared by the LRU key/value cache RTL.
// No dependencies; included by lru_key_value_cache, the module that carries assertions.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Implication checked at every rising clock edge, disabled while in reset.
`define LKV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every rising clock edge, disabled while in reset.
`define LKV_ASSERT_ALWAYS(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cons)) \
    else $error(msg);

`endif

[design/lkv_pkg.sv]
// Package for the LRU key/value cache: sizes, widths and the cell interface types.
// No dependencies; used by lkv_cell and lru_key_value_cache.
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int AGE_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [KEY_W-1:0] key;         // request key, for compare and write
    logic [VAL_W-1:0] value;       // request value, for write
    logic [AGE_W-1:0] victim_age;  // age held by the least recent entry
    logic             upd;         // apply the update this cycle
    logic             age_all;     // every valid unselected entry ages
    logic [AGE_W-1:0] touch_age;   // otherwise only entries younger than this age
    logic             wr_key;
    logic             wr_data;
    logic             set_valid;
  } cell_cmd_t;

  // Status reported by each cell.
  typedef struct packed {
    logic             valid;
    logic             match;
    logic             victim;
    logic             free;
    logic [AGE_W-1:0] age;
    logic [VAL_W-1:0] data;
  } cell_stat_t;

endpackage

[design/lkv_cell.sv]
// One entry of the LRU key/value cache: valid bit, key, value and recency age.
// Depends on lkv_pkg; a row of these is instantiated by lru_key_value_cache.
module lkv_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lkv_pkg::cell_cmd_t cmd_i,
  input  logic               sel_i,
  input  logic               prev_valid_i,
  output lkv_pkg::cell_stat_t stat_o
);

  logic                      valid_q;
  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] data_q;
  logic [lkv_pkg::AGE_W-1:0] age_q;

  // Entries fill from the low end and are never dropped, so the first free
  // slot is the invalid cell whose lower neighbor is valid.
  always_comb begin
    stat_o.valid  = valid_q;
    stat_o.match  = valid_q && (key_q == cmd_i.key);
    stat_o.victim = valid_q && (age_q == cmd_i.victim_age);
    stat_o.free   = !valid_q && prev_valid_i;
    stat_o.age    = age_q;
    stat_o.data   = data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (cmd_i.upd) begin
      if (sel_i) begin
        age_q <= '0;
        if (cmd_i.set_valid) begin
          valid_q <= 1'b1;
        end
      end else if (valid_q && (cmd_i.age_all || (age_q < cmd_i.touch_age))) begin
        age_q <= age_q + lkv_pkg::AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && sel_i) begin
      if (cmd_i.wr_key) begin
        key_q <= cmd_i.key;
      end
      if (cmd_i.wr_data) begin
        data_q <= cmd_i.value;
      end
    end
  end

endmodule

[design/lru_key_value_cache.sv]
// Top level of the LRU key/value cache: controller, capacity register and cell row.
// Depends on lkv_pkg, lkv_cell and lru_key_value_cache_macros.svh.
//
//   Port group   Direction  Handshake                  Payload
//   req          in         req_valid_i / req_ready_o  req_type_i, key_i, write_value_i
//   rsp          out        rsp_valid_o / rsp_ready_i  hit_o, read_value_o
//   cfg          in         cfg_we_i (no wait)         cfg_wdata_i (capacity)
//
// Each request passes through a lookup cycle, in which every cell compares its
// key and the controller picks the target entry, then an update cycle, in which
// the cells apply the new ages and data. A new request is taken during the update
// cycle, so the next lookup follows without passing through the idle state.
// While the response register is full and not taken, the block waits in the
// lookup cycle. Reset clears the valid bits, ages and occupancy at once; no clearing pass.
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  logic                      req_type_i,
  input  logic [lkv_pkg::KEY_W-1:0] key_i,
  input  logic [lkv_pkg::VAL_W-1:0] write_value_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output logic                      hit_o,
  output logic [lkv_pkg::VAL_W-1:0] read_value_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_e;

  state_e                         state_q;
  logic [lkv_pkg::CAP_W-1:0]      cap_q;
  logic [lkv_pkg::CNT_W-1:0]      count_q;
  logic                           req_put_q;
  logic [lkv_pkg::KEY_W-1:0]      req_key_q;
  logic [lkv_pkg::VAL_W-1:0]      req_val_q;
  logic                           rsp_valid_q;
  logic                           hit_q;
  logic [lkv_pkg::VAL_W-1:0]      read_q;
  logic [lkv_pkg::ENTRIES-1:0]    sel_q;
  logic                           age_all_q;
  logic [lkv_pkg::AGE_W-1:0]      touch_age_q;
  logic                           wr_key_q;
  logic                           wr_data_q;
  logic                           set_valid_q;

  lkv_pkg::cell_cmd_t             cmd;
  lkv_pkg::cell_stat_t            stat [lkv_pkg::ENTRIES];
  logic [lkv_pkg::ENTRIES:0]      valid_chain;

  logic [lkv_pkg::ENTRIES-1:0]    valid_vec;
  logic [lkv_pkg::ENTRIES-1:0]    hit_vec;
  logic [lkv_pkg::ENTRIES-1:0]    victim_vec;
  logic [lkv_pkg::ENTRIES-1:0]    free_vec;
  logic                           hit_any;
  logic [lkv_pkg::AGE_W-1:0]      hit_age;
  logic [lkv_pkg::VAL_W-1:0]      hit_data;
  logic [lkv_pkg::CNT_W-1:0]      eff_cap;
  logic                           full;
  logic                           rsp_free;

  // Capacity register. Zero behaves as one; values above the entry count saturate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = lkv_pkg::CNT_W'(1);
    end else if (int'(cap_q) > lkv_pkg::ENTRIES) begin
      eff_cap = lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
    end else begin
      eff_cap = lkv_pkg::CNT_W'(cap_q);
    end
  end

  assign full = (count_q >= eff_cap);

  // The valid entries always hold the distinct ages 0 .. count-1, so the least
  // recent entry is the one whose age equals count-1.
  always_comb begin
    cmd.key        = req_key_q;
    cmd.value      = req_val_q;
    cmd.victim_age = lkv_pkg::AGE_W'(count_q - lkv_pkg::CNT_W'(1));
    cmd.upd        = (state_q == S_UPD);
    cmd.age_all    = age_all_q;
    cmd.touch_age  = touch_age_q;
    cmd.wr_key     = wr_key_q;
    cmd.wr_data    = wr_data_q;
    cmd.set_valid  = set_valid_q;
  end

  // The row of cells. Each cell hands its valid bit to its upper neighbor, which
  // uses it to tell whether it is the first free slot.
  assign valid_chain[0] = 1'b1;

  for (genvar g = 0; g < lkv_pkg::ENTRIES; g++) begin : g_cell
    lkv_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .sel_i       (sel_q[g]),
      .prev_valid_i(valid_chain[g]),
      .stat_o      (stat[g])
    );
    assign valid_chain[g+1] = stat[g].valid;
    assign valid_vec[g]     = stat[g].valid;
    assign hit_vec[g]       = stat[g].match;
    assign victim_vec[g]    = stat[g].victim;
    assign free_vec[g]      = stat[g].free;
  end

  // Keys are unique among valid entries, so at most one cell matches and the
  // age and data of the hit can be gathered with a plain OR.
  always_comb begin
    hit_age  = '0;
    hit_data = '0;
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      hit_age  = hit_age | (stat[i].match ? stat[i].age : '0);
      hit_data = hit_data | (stat[i].match ? stat[i].data : '0);
    end
  end

  assign hit_any  = |hit_vec;
  assign rsp_free = !rsp_valid_q || rsp_ready_i;

  // Controller: request capture, target selection and the response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      req_put_q   <= 1'b0;
      req_key_q   <= '0;
      req_val_q   <= '0;
      rsp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      read_q      <= '0;
      sel_q       <= '0;
      age_all_q   <= 1'b0;
      touch_age_q <= '0;
      wr_key_q    <= 1'b0;
      wr_data_q   <= 1'b0;
      set_valid_q <= 1'b0;
    end else begin
      if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_put_q <= req_type_i;
            req_key_q <= key_i;
            req_val_q <= write_value_i;
            state_q   <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (rsp_free) begin
            rsp_valid_q <= 1'b1;
            hit_q       <= hit_any;
            read_q      <= (hit_any && !req_put_q) ? hit_data : '0;
            touch_age_q <= hit_age;
            if (hit_any) begin
              // Hit: the entry becomes the most recent; a put rewrites its value.
              sel_q       <= hit_vec;
              age_all_q   <= 1'b0;
              wr_key_q    <= 1'b0;
              wr_data_q   <= req_put_q;
              set_valid_q <= 1'b0;
            end else if (req_put_q && full) begin
              // Put miss at capacity: the least recent entry is replaced in place.
              sel_q       <= victim_vec;
              age_all_q   <= 1'b1;
              wr_key_q    <= 1'b1;
              wr_data_q   <= 1'b1;
              set_valid_q <= 1'b0;
            end else if (req_put_q) begin
              // Put miss with room: fill the lowest free slot.
              sel_q       <= free_vec;
              age_all_q   <= 1'b1;
              wr_key_q    <= 1'b1;
              wr_data_q   <= 1'b1;
              set_valid_q <= 1'b1;
            end else begin
              // Get miss leaves the entries alone.
              sel_q       <= '0;
              age_all_q   <= 1'b0;
              wr_key_q    <= 1'b0;
              wr_data_q   <= 1'b0;
              set_valid_q <= 1'b0;
            end
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (set_valid_q) begin
            count_q <= count_q + lkv_pkg::CNT_W'(1);
          end
          if (req_valid_i) begin
            req_put_q <= req_type_i;
            req_key_q <= key_i;
            req_val_q <= write_value_i;
            state_q   <= S_LOOK;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o  = (state_q == S_IDLE) || (state_q == S_UPD);
  assign rsp_valid_o  = rsp_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = read_q;

  `LKV_ASSERT_ALWAYS(a_count_matches_valid, clk_i, rst_ni,
    $countones(valid_vec) == int'(count_q), "occupancy differs from valid entry count")
  `LKV_ASSERT_ALWAYS(a_count_bounded, clk_i, rst_ni,
    int'(count_q) <= lkv_pkg::ENTRIES, "occupancy above entry count")
  `LKV_ASSERT_IMPLY(a_key_unique, clk_i, rst_ni,
    state_q == S_LOOK, $onehot0(hit_vec), "key held by more than one entry")
  `LKV_ASSERT_IMPLY(a_victim_unique, clk_i, rst_ni,
    state_q == S_LOOK && count_q != '0, $onehot(victim_vec), "no single least recent entry")
  `LKV_ASSERT_IMPLY(a_sel_onehot, clk_i, rst_ni,
    state_q == S_UPD, $onehot0(sel_q), "update targets more than one entry")

endmodule
